@@ hdl/gbsm_pkg.sv @@
package gbsm_pkg;

    // default width of the consumed length count
    localparam int LENGTH_BITS_DEF = 10;

    // classified word queue depth (power of two)
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_CASEFOLD = 2'd0;
    localparam logic [1:0] CFG_NOESCAPE = 2'd1;
    localparam logic [1:0] CFG_PATHNAME = 2'd2;

    // result codes
    localparam logic [1:0] RES_NOMATCH   = 2'd0;
    localparam logic [1:0] RES_MATCH     = 2'd1;
    localparam logic [1:0] RES_MALFORMED = 2'd2;
    localparam logic [1:0] RES_UNFINISH  = 2'd3;

    // pattern characters
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_BANG     = 8'h21;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // parser phases
    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_BODY,
        PH_ESC,
        PH_DASH,
        PH_RANGE_ESC,
        PH_DONE
    } phase_t;

    // one classified pattern word, front to back
    typedef struct packed {
        logic       start;
        logic       is_nul;
        logic       is_bang;
        logic       is_rbracket;
        logic       is_escape;
        logic       is_dash;
        logic       slash_forbid;
        logic       casefold;
        logic [7:0] pbyte;
        logic [7:0] subject;
    } cls_word_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // ASCII lower-case fold when enabled
    function automatic logic [7:0] fold_byte(input logic [7:0] x, input logic cf);
        logic [7:0] r;
        r = x;
        if (cf && x >= CH_UPPER_A && x <= CH_UPPER_Z) begin
            r = x + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

@@ hdl/gbsm_front.sv @@
module gbsm_front
    import gbsm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic       cfg_data,
    input  logic       s_tvalid,
    input  logic       s_tuser,
    input  logic [7:0] s_pattern,
    input  logic [7:0] s_subject,
    output cls_word_t  word,
    output logic       push
);

    logic casefold_reg;
    logic noescape_reg;
    logic pathname_reg;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            casefold_reg <= 1'b0;
            noescape_reg <= 1'b0;
            pathname_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CASEFOLD: casefold_reg <= cfg_data;
                CFG_NOESCAPE: noescape_reg <= cfg_data;
                CFG_PATHNAME: pathname_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // classify the incoming byte
    always_comb begin
        word.start        = s_tuser;
        word.is_nul       = (s_pattern == CH_NUL);
        word.is_bang      = (s_pattern == CH_BANG);
        word.is_rbracket  = (s_pattern == CH_RBRACKET);
        word.is_escape    = (s_pattern == CH_BSLASH) && !noescape_reg;
        word.is_dash      = (s_pattern == CH_DASH);
        word.slash_forbid = pathname_reg && (s_subject == CH_SLASH);
        word.casefold     = casefold_reg;
        word.pbyte        = s_pattern;
        word.subject      = s_subject;
    end

    assign push = s_tvalid;

endmodule

@@ hdl/gbsm_queue.sv @@
module gbsm_queue
    import gbsm_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cls_word_t     push_word,
    input  logic          pop,
    output cls_word_t     pop_word,
    output queue_status_t status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    cls_word_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == DEPTH_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign pop_word = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hdl/gbsm_back.sv @@
module gbsm_back
    import gbsm_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  queue_status_t          qstat,
    input  cls_word_t              word,
    output logic                   pop,
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic [1:0]             res_code,
    output logic [LENGTH_BITS-1:0] res_len
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    phase_t                 phase_reg,  phase_next;
    logic                   neg_reg,    neg_next;
    logic                   match_reg,  match_next;
    logic                   pnone_reg,  pnone_next;
    logic [7:0]             pbyte_reg,  pbyte_next;
    logic [7:0]             subj_reg,   subj_next;
    logic                   slashf_reg, slashf_next;
    logic [LENGTH_BITS-1:0] cnt_reg,    cnt_next;
    logic                   ovalid_reg, ovalid_next;
    logic [1:0]             ocode_reg,  ocode_next;
    logic [LENGTH_BITS-1:0] olen_reg,   olen_next;

    logic slot_free;

    assign slot_free = !ovalid_reg || res_ready;
    assign pop       = slot_free && !qstat.empty;
    assign res_valid = ovalid_reg;
    assign res_code  = ocode_reg;
    assign res_len   = olen_reg;

    // parser step on one popped word
    always_comb begin
        phase_t     ph;
        logic       neg;
        logic       mat;
        logic       pnone;
        logic [7:0] pb;
        logic [7:0] subj;
        logic       slf;
        logic [7:0] fsubj;
        logic [7:0] fbyte;
        logic [7:0] flo;
        logic       lit_hit;
        logic       dash_hit;
        logic       range_hit;
        logic       emit;
        logic [1:0] code;
        logic [LENGTH_BITS-1:0] cnt;
        logic [LENGTH_BITS-1:0] cnt_inc;

        ph    = phase_reg;
        neg   = neg_reg;
        mat   = match_reg;
        pnone = pnone_reg;
        pb    = pbyte_reg;
        subj  = subj_reg;
        slf   = slashf_reg;
        cnt   = cnt_reg;
        emit  = 1'b0;
        code  = RES_NOMATCH;

        // a new set clears the parse state
        if (word.start) begin
            ph    = PH_FIRST;
            neg   = 1'b0;
            mat   = 1'b0;
            pnone = 1'b1;
            pb    = '0;
            subj  = word.subject;
            slf   = word.slash_forbid;
            cnt   = '0;
        end

        cnt_inc   = (cnt == LEN_MAX) ? cnt : cnt + 1'b1;
        fsubj     = fold_byte(subj, word.casefold);
        fbyte     = fold_byte(word.pbyte, word.casefold);
        flo       = fold_byte(pb, word.casefold);
        lit_hit   = !slf && (fbyte == fsubj);
        dash_hit  = !slf && (fold_byte(CH_DASH, word.casefold) == fsubj);
        range_hit = !slf && (flo <= fsubj) && (fsubj <= fbyte);

        if (ph == PH_DONE) begin
            // bytes after a result are dropped
        end else if (word.is_nul) begin
            emit = 1'b1;
            code = (ph == PH_DASH) ? RES_UNFINISH : RES_MALFORMED;
            ph   = PH_DONE;
        end else begin
            cnt = cnt_inc;
            unique case (ph)
                PH_FIRST, PH_SECOND: begin
                    if (ph == PH_FIRST && word.is_bang) begin
                        neg = 1'b1;
                        ph  = PH_SECOND;
                    end else if (word.is_rbracket) begin
                        // leading bracket is a literal member
                        if (subj == CH_RBRACKET) mat = 1'b1;
                        pnone = 1'b0;
                        pb    = CH_RBRACKET;
                        ph    = PH_BODY;
                    end else if (word.is_escape) begin
                        ph = PH_ESC;
                    end else begin
                        // previous char is none here, so a dash is literal
                        if (lit_hit) mat = 1'b1;
                        pnone = 1'b0;
                        pb    = word.pbyte;
                        ph    = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (word.is_rbracket) begin
                        emit = 1'b1;
                        code = {1'b0, mat ^ neg};
                        ph   = PH_DONE;
                    end else if (word.is_escape) begin
                        ph = PH_ESC;
                    end else if (word.is_dash && !pnone) begin
                        ph = PH_DASH;
                    end else begin
                        if (lit_hit) mat = 1'b1;
                        pnone = 1'b0;
                        pb    = word.pbyte;
                    end
                end
                PH_ESC: begin
                    if (lit_hit) mat = 1'b1;
                    pnone = 1'b0;
                    pb    = word.pbyte;
                    ph    = PH_BODY;
                end
                PH_DASH: begin
                    if (word.is_rbracket) begin
                        // trailing dash is a literal
                        if (dash_hit) mat = 1'b1;
                        emit = 1'b1;
                        code = {1'b0, mat ^ neg};
                        ph   = PH_DONE;
                    end else if (word.is_escape) begin
                        ph = PH_RANGE_ESC;
                    end else begin
                        if (range_hit) mat = 1'b1;
                        pnone = 1'b1;
                        ph    = PH_BODY;
                    end
                end
                PH_RANGE_ESC: begin
                    if (range_hit) mat = 1'b1;
                    pnone = 1'b1;
                    ph    = PH_BODY;
                end
                default: ph = PH_DONE;
            endcase
        end

        // commit only when a word is popped
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        match_next  = match_reg;
        pnone_next  = pnone_reg;
        pbyte_next  = pbyte_reg;
        subj_next   = subj_reg;
        slashf_next = slashf_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg && !res_ready;
        ocode_next  = ocode_reg;
        olen_next   = olen_reg;
        if (pop) begin
            phase_next  = ph;
            neg_next    = neg;
            match_next  = mat;
            pnone_next  = pnone;
            pbyte_next  = pb;
            subj_next   = subj;
            slashf_next = slf;
            cnt_next    = cnt;
            if (emit) begin
                ovalid_next = 1'b1;
                ocode_next  = code;
                olen_next   = cnt;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_FIRST;
            neg_reg    <= 1'b0;
            match_reg  <= 1'b0;
            pnone_reg  <= 1'b1;
            pbyte_reg  <= '0;
            subj_reg   <= '0;
            slashf_reg <= 1'b0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            match_reg  <= match_next;
            pnone_reg  <= pnone_next;
            pbyte_reg  <= pbyte_next;
            subj_reg   <= subj_next;
            slashf_reg <= slashf_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        ocode_reg <= ocode_next;
        olen_reg  <= olen_next;
    end

endmodule

@@ hdl/glob_bracket_set_matcher.sv @@
// Bracket-set matcher for glob patterns.
// Input stream s_*: one word per pattern byte, starting after the '['.
//   s_tuser marks the first byte of a set and latches the subject char
//   carried in s_tdata[15:8]. The byte 0 ends the pattern string.
// Output stream m_*: one word per set, given at the closing ']' or at NUL,
//   carrying the result code and the consumed byte count (saturating).
// Config channel cfg_*: index 0 casefold, 1 noescape, 2 pathname; always
//   ready; write only while no set is in flight.
// Throughput is one pattern byte per cycle while results are accepted: the
//   parser state update is combinational and registered on each pop, and a
//   two-entry word queue sits between the classifier and the parser.
// m_tvalid rises once the parser has popped the closing byte from the queue
//   and loaded the result register; queued words or a held result delay it.
// Reset (aresetn low, synchronous) clears config, queue and parser; parsing
//   without a set start runs against subject 0.
// When m_tready is low with a result pending, the result register holds and
//   the parser stops popping; the queue fills and then s_tready drops.
module glob_bracket_set_matcher
    import gbsm_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pattern_byte[7:0], subject_char[15:8]
    input  logic        s_tuser,   // start_set
    output logic        m_tvalid,
    input  logic        m_tready,
    // set_result[1:0], consumed_length[LENGTH_BITS+1:2], zero fill above
    output logic [((2 + LENGTH_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int OUT_W = ((2 + LENGTH_BITS + 7) / 8) * 8;

    cls_word_t              front_word;
    cls_word_t              back_word;
    logic                   front_push;
    logic                   back_pop;
    queue_status_t          qstat;
    logic [1:0]             res_code;
    logic [LENGTH_BITS-1:0] res_len;

    assign s_tready = !qstat.full;
    assign m_tdata  = OUT_W'({res_len, res_code});

    gbsm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tuser   (s_tuser),
        .s_pattern (s_tdata[7:0]),
        .s_subject (s_tdata[15:8]),
        .word      (front_word),
        .push      (front_push)
    );

    gbsm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .push_word (front_word),
        .pop       (back_pop),
        .pop_word  (back_word),
        .status    (qstat)
    );

    gbsm_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .qstat     (qstat),
        .word      (back_word),
        .pop       (back_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_code  (res_code),
        .res_len   (res_len)
    );

endmodule

@@ hdl/gbsm_checker.sv @@
module gbsm_checker
    import gbsm_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [1:0]             res_code,
    input logic [LENGTH_BITS-1:0] res_len
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(res_code) && $stable(res_len))
        else $error("stalled result changed");

    // a closing bracket is always counted
    a_close_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_code == RES_MATCH || res_code == RES_NOMATCH)
            |-> res_len != '0)
        else $error("match result with zero length");

    // an unfinished range needs a start char and a dash before the NUL
    a_unfinished_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_code == RES_UNFINISH |-> res_len >= LENGTH_BITS'(2))
        else $error("unfinished range too short");

endmodule

bind glob_bracket_set_matcher gbsm_checker #(
    .LENGTH_BITS (LENGTH_BITS)
) u_gbsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res_code (m_tdata[1:0]),
    .res_len  (m_tdata[LENGTH_BITS+1:2])
);

@@ tb/sv/tb_glob_bracket_set_matcher.sv @@
module tb_glob_bracket_set_matcher;
    import gbsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_BITS = LENGTH_BITS_DEF;
    localparam logic [LEN_BITS-1:0] LEN_SAT = {LEN_BITS{1'b1}};
    localparam logic [8:0] NO_PREV = 9'h100;
    localparam int DATA_W = ((2 + LEN_BITS + 7) / 8) * 8;

    // one verdict word as seen on m_tdata
    typedef struct {
        logic [1:0]          code;
        logic [LEN_BITS-1:0] len;
    } verdict_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = CFG_CASEFOLD;
    logic                cfg_data = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata = '0;   // pattern_byte[7:0], subject_char[15:8]
    logic                s_tuser = 1'b0; // start_set
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;        // set_result[1:0], consumed_length[11:2]

    // option shadow of the block's registers
    logic cf_on = 1'b0;
    logic ne_on = 1'b0;
    logic pn_on = 1'b0;

    // bracket parser shadow state
    phase_t              phase = PH_FIRST;
    logic                negated = 1'b0;
    logic                hit = 1'b0;
    logic [8:0]          prev_ch = NO_PREV;
    logic [7:0]          subj_latch = '0;
    logic                slash_block = 1'b0;
    logic [LEN_BITS-1:0] count = '0;

    verdict_t   pending_verdicts[$];
    logic [7:0] set_bytes[$];
    int         fault_count = 0;
    bit         steady = 1'b0;

    glob_bracket_set_matcher DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // receiver stalls about a quarter of the time unless in a steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 25);
    end

    function automatic void note_fault(input string msg);
        if (fault_count < 10) $display("%0t ns: %s", $realtime, msg);
        fault_count++;
    endfunction

    // ---------------- verdict predictor ----------------

    function automatic logic [7:0] fold_case(input logic [7:0] x);
        if (cf_on && x >= CH_UPPER_A && x <= CH_UPPER_Z) return {x[7:6], 1'b1, x[4:0]};
        return x;
    endfunction

    function automatic void take_member(input logic [7:0] ch);
        if (!slash_block && fold_case(ch) == fold_case(subj_latch)) hit = 1'b1;
        prev_ch = {1'b0, ch};
    endfunction

    function automatic void take_span(input logic [7:0] hi_ch);
        logic [7:0] lo, hi, c;
        lo = fold_case(prev_ch[7:0]);
        hi = fold_case(hi_ch);
        c  = fold_case(subj_latch);
        if (!slash_block && lo <= c && c <= hi) hit = 1'b1;
        prev_ch = NO_PREV;
    endfunction

    function automatic void close_set(input logic [1:0] code, output verdict_t v);
        v.code = code;
        v.len  = count;
        phase  = PH_DONE;
    endfunction

    function automatic logic [1:0] hit_code();
        return (hit ^ negated) ? RES_MATCH : RES_NOMATCH;
    endfunction

    // advances the shadow parser by one word; returns 1 when a verdict falls out
    function automatic bit predict_verdict(input logic first, input logic [7:0] b,
                                           input logic [7:0] s, output verdict_t v);
        v.code = RES_NOMATCH;
        v.len  = '0;
        if (first) begin
            phase       = PH_FIRST;
            negated     = 1'b0;
            hit         = 1'b0;
            prev_ch     = NO_PREV;
            subj_latch  = s;
            slash_block = pn_on && (s == CH_SLASH);
            count       = '0;
        end
        if (phase == PH_DONE) return 0;
        if (b == CH_NUL) begin
            close_set((phase == PH_DASH) ? RES_UNFINISH : RES_MALFORMED, v);
            return 1;
        end
        if (count != LEN_SAT) count++;

        // leading '!' and leading ']' only count at the head of the set
        if (phase == PH_FIRST && b == CH_BANG) begin
            negated = 1'b1;
            phase   = PH_SECOND;
            return 0;
        end
        if ((phase == PH_FIRST || phase == PH_SECOND) && b == CH_RBRACKET) begin
            if (subj_latch == CH_RBRACKET) hit = 1'b1;
            prev_ch = {1'b0, CH_RBRACKET};
            phase   = PH_BODY;
            return 0;
        end
        if (phase == PH_FIRST || phase == PH_SECOND) phase = PH_BODY;

        case (phase)
            PH_BODY: begin
                if (b == CH_RBRACKET) begin
                    close_set(hit_code(), v);
                    return 1;
                end
                if (b == CH_BSLASH && !ne_on) phase = PH_ESC;
                else if (b == CH_DASH && prev_ch != NO_PREV) phase = PH_DASH;
                else take_member(b);
            end
            PH_ESC: begin
                take_member(b);
                phase = PH_BODY;
            end
            PH_DASH: begin
                // dash right before the closing bracket is a plain member
                if (b == CH_RBRACKET) begin
                    take_member(CH_DASH);
                    close_set(hit_code(), v);
                    return 1;
                end
                if (b == CH_BSLASH && !ne_on) begin
                    phase = PH_RANGE_ESC;
                end else begin
                    take_span(b);
                    phase = PH_BODY;
                end
            end
            PH_RANGE_ESC: begin
                take_span(b);
                phase = PH_BODY;
            end
            default: phase = PH_DONE;
        endcase
        return 0;
    endfunction

    // ---------------- drivers ----------------

    task automatic send_word(input logic first, input logic [7:0] pbyte,
                             input logic [7:0] subj);
        verdict_t v;
        while (!steady && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        s_tdata  <= {subj, pbyte};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (predict_verdict(first, pbyte, subj, v)) pending_verdicts.push_back(v);
    endtask

    // sends set_bytes with the subject on the opening word
    task automatic send_set(input logic [7:0] subj);
        for (int i = 0; i < set_bytes.size(); i++) begin
            send_word(i == 0, set_bytes[i], (i == 0) ? subj : 8'($urandom_range(255)));
        end
    endtask

    // hold the sender until every verdict is in and the pipe is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic program_options(input logic cf, input logic ne, input logic pn);
        logic [1:0] idx [3];
        logic       val [3];
        idx = '{CFG_CASEFOLD, CFG_NOESCAPE, CFG_PATHNAME};
        val = '{cf, ne, pn};
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (idx[k])
                CFG_CASEFOLD: cf_on = val[k];
                CFG_NOESCAPE: ne_on = val[k];
                CFG_PATHNAME: pn_on = val[k];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // ---------------- random set builder ----------------

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2: c = 8'($urandom_range(8'h61, 8'h7A));
            3, 4:    c = 8'($urandom_range(8'h41, 8'h5A));
            5:       c = CH_SLASH;
            default: c = 8'($urandom_range(255, 1));
        endcase
        if (c == CH_RBRACKET) c = 8'h5B;
        return c;
    endfunction

    function automatic void build_set();
        int tail;
        set_bytes.delete();
        if ($urandom_range(99) < 30) set_bytes.push_back(CH_BANG);
        if ($urandom_range(99) < 20) set_bytes.push_back(CH_RBRACKET);
        else if ($urandom_range(99) < 15) set_bytes.push_back(CH_DASH);
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: set_bytes.push_back(plain_char());
                4, 5: begin
                    set_bytes.push_back(CH_BSLASH);
                    set_bytes.push_back(8'($urandom_range(255, 1)));
                end
                default: begin
                    set_bytes.push_back(plain_char());
                    set_bytes.push_back(CH_DASH);
                    if ($urandom_range(99) < 20) begin
                        set_bytes.push_back(CH_BSLASH);
                        set_bytes.push_back(8'($urandom_range(255, 1)));
                    end else begin
                        set_bytes.push_back(plain_char());
                    end
                end
            endcase
        end
        if ($urandom_range(99) < 15) set_bytes.push_back(CH_DASH);
        tail = $urandom_range(0, 19);
        if (tail < 16) begin
            set_bytes.push_back(CH_RBRACKET);
        end else if (tail == 16) begin
            set_bytes.push_back(CH_NUL);
        end else if (tail == 17) begin
            set_bytes.push_back(CH_DASH);
            set_bytes.push_back(CH_NUL);
        end else if (tail == 18) begin
            set_bytes.push_back(CH_BSLASH);
            set_bytes.push_back(CH_NUL);
        end
        // no closing byte at all: the next set start cuts it off
        if (set_bytes.size() == 0) set_bytes.push_back(CH_RBRACKET);
    endfunction

    // subjects lean toward set members, flipped case, slash, bracket and dash
    function automatic logic [7:0] pick_subject();
        logic [7:0] c;
        c = set_bytes[$urandom_range(0, set_bytes.size() - 1)];
        case ($urandom_range(0, 6))
            0, 1: return 8'($urandom_range(255));
            2, 3: return c;
            4:    return ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A) ? (c ^ 8'h20) : c;
            5:    return CH_SLASH;
            default: return ($urandom_range(1)) ? CH_RBRACKET : CH_DASH;
        endcase
    endfunction

    // ---------------- tests ----------------

    // words before any set start parse against subject 0
    task automatic test_no_start_after_reset();
        send_word(1'b0, "a", 8'($urandom_range(255)));
        send_word(1'b0, CH_RBRACKET, 8'($urandom_range(255)));
    endtask

    task automatic test_set_syntax();
        set_bytes = '{CH_RBRACKET, CH_RBRACKET};                 // leading bracket member
        send_set(CH_RBRACKET);
        set_bytes = '{CH_BANG, "x", CH_RBRACKET};                // negation
        send_set("x");
        set_bytes = '{CH_DASH, CH_RBRACKET};                     // leading dash
        send_set(CH_DASH);
        set_bytes = '{"a", CH_DASH, CH_BSLASH, 8'hFF, CH_RBRACKET}; // escaped range end
        send_set(8'hFF);
        set_bytes = '{"a", CH_DASH, CH_RBRACKET};                // trailing dash
        send_set(CH_DASH);
    endtask

    task automatic test_broken_sets();
        set_bytes = '{CH_BSLASH, CH_NUL};                        // escape then NUL
        send_set("q");
        set_bytes = '{"a", CH_DASH, CH_NUL, "x", CH_RBRACKET};   // open range, then ignored
        send_set("a");
        set_bytes = '{CH_NUL};                                   // empty pattern
        send_set(8'h00);
    endtask

    task automatic test_options();
        program_options(1'b1, 1'b0, 1'b0);
        set_bytes = '{"a", CH_DASH, "z", CH_RBRACKET};
        send_set("Q");
        settle();
        program_options(1'b0, 1'b1, 1'b0);
        set_bytes = '{CH_BSLASH, CH_RBRACKET};
        send_set(CH_BSLASH);
        settle();
        program_options(1'b0, 1'b0, 1'b1);
        set_bytes = '{CH_BANG, CH_SLASH, CH_RBRACKET};
        send_set(CH_SLASH);
        settle();
    endtask

    // a set long enough for the length count to pin at its top
    task automatic test_length_saturation();
        program_options(1'b0, 1'b0, 1'b0);
        set_bytes.delete();
        repeat (int'(LEN_SAT) + 40) set_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
        set_bytes.push_back(CH_RBRACKET);
        send_set("A");
        settle();
    endtask

    task automatic test_random_sets();
        int sent;
        for (int mode = 7; mode >= 0; mode--) begin
            program_options(mode[0], mode[1], mode[2]);
            steady = (mode == 5);
            sent = 0;
            while (sent < 80) begin
                if ($urandom_range(99) < 10) begin
                    // noise: arbitrary bytes with stray set starts
                    repeat ($urandom_range(1, 6)) begin
                        send_word($urandom_range(3) == 0, 8'($urandom_range(255)),
                                  8'($urandom_range(255)));
                        sent++;
                    end
                end else begin
                    build_set();
                    send_set(pick_subject());
                    sent += set_bytes.size();
                end
            end
            settle();
            steady = 1'b0;
        end
    endtask

    // ---------------- verdict checker ----------------

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                note_fault($sformatf("verdict with none expected: code %0d len %0d",
                                     m_tdata[1:0], m_tdata[LEN_BITS+1:2]));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[1:0] !== want.code)
                    note_fault($sformatf("set_result expected %0d got %0d",
                                         want.code, m_tdata[1:0]));
                if (m_tdata[LEN_BITS+1:2] !== want.len)
                    note_fault($sformatf("consumed_length expected %0d got %0d",
                                         want.len, m_tdata[LEN_BITS+1:2]));
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_no_start_after_reset();
        test_set_syntax();
        test_broken_sets();
        settle();
        test_options();
        test_length_saturation();
        test_random_sets();
        settle();
        if (pending_verdicts.size() != 0)
            note_fault($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
        if (fault_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(3_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
